// ----- rtl/core/iso_fs_pkg.sv -----
// ----------------------------------------------------------------------------
// iso_fs_pkg : shared types and tables for the message field splitter
// segment codes, element kind table and body length rule
// ----------------------------------------------------------------------------
package iso_fs_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 14;

  // width of a decoded bcd length (two prefix bytes, up to 9999)
  localparam int unsigned PFX_VAL_W = 14;
  localparam int unsigned BODY_W    = 15;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    SEG_LEN    = 3'd0,
    SEG_TPDU   = 3'd1,
    SEG_HEAD   = 3'd2,
    SEG_TYPE   = 3'd3,
    SEG_BITMAP = 3'd4,
    SEG_ELEM   = 3'd5,
    SEG_IDLE   = 3'd6
  } seg_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_UNDEF = 2'd2,
    ST_BCD   = 2'd3
  } status_t;

  // element kind: below 0x80 is a fixed byte count, else a prefixed kind
  localparam logic [7:0] KIND_UND = 8'h00;
  localparam logic [7:0] KIND_V1H = 8'h81;  // 1-byte prefix, halved body
  localparam logic [7:0] KIND_V2H = 8'h82;  // 2-byte prefix, halved body
  localparam logic [7:0] KIND_V2R = 8'h83;  // 2-byte prefix, raw body
  localparam logic [7:0] KIND_V2E = 8'h84;  // 2-byte prefix, body rounded to even

  function automatic logic [7:0] elem_kind(input logic [6:0] n);
    logic [7:0] k;
    case (n)
      7'd2:  k = KIND_V1H;
      7'd3:  k = 8'd3;
      7'd4:  k = 8'd6;
      7'd5:  k = 8'd16;
      7'd6:  k = 8'd4;
      7'd11: k = 8'd3;
      7'd12: k = 8'd3;
      7'd13: k = 8'd2;
      7'd14: k = 8'd2;
      7'd15: k = 8'd2;
      7'd22: k = 8'd2;
      7'd23: k = 8'd2;
      7'd25: k = 8'd1;
      7'd26: k = 8'd1;
      7'd32: k = KIND_V1H;
      7'd35: k = KIND_V1H;
      7'd36: k = KIND_V2H;
      7'd37: k = 8'd12;
      7'd38: k = 8'd6;
      7'd39: k = 8'd2;
      7'd41: k = 8'd8;
      7'd42: k = 8'd15;
      7'd44: k = KIND_V1H;
      7'd46: k = KIND_V2H;
      7'd47: k = KIND_V2R;
      7'd48: k = KIND_V2E;
      7'd49: k = 8'd3;
      7'd50: k = KIND_V2R;
      7'd52: k = 8'd8;
      7'd53: k = 8'd8;
      7'd54: k = KIND_V2R;
      7'd55: k = KIND_V2R;
      7'd56: k = KIND_V2R;
      7'd58: k = KIND_V2R;
      7'd59: k = KIND_V2R;
      7'd60: k = KIND_V2H;
      7'd61: k = KIND_V2H;
      7'd62: k = KIND_V2R;
      7'd63: k = KIND_V2R;
      7'd64: k = 8'd8;
      default: k = KIND_UND;
    endcase
    return k;
  endfunction

  // body bytes that follow a prefix of value v, before saturation
  function automatic logic [BODY_W-1:0] body_len(input logic [7:0] kind,
                                                  input logic [PFX_VAL_W-1:0] v);
    logic [BODY_W-1:0] vx;
    logic [BODY_W-1:0] n;
    vx = BODY_W'(v);
    case (kind)
      KIND_V2R: n = vx;
      KIND_V2E: n = vx + BODY_W'(v[0]);
      default:  n = (vx + BODY_W'(1)) >> 1;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/core/iso8583_field_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// iso8583_field_splitter_unit : byte tagger for iso 8583 messages
// datapath: input register, then result register; a byte held in the input
// register is tagged and moves on once the result register is free or read
// throughput: one byte per cycle, limited only by downstream tready
// reset: synchronous active-low rst_n; parser returns to the length segment
// and both pipeline registers empty; state also returns there after each
// byte flagged as end of message
// ----------------------------------------------------------------------------
module iso8583_field_splitter_unit #(
  parameter int unsigned LENGTH_BITS = iso_fs_pkg::LENGTH_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input byte stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [iso_fs_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] msg_byte
  input  logic                                 in_tlast,   // end_of_message
  // tagged byte stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [2:0] segment, [9:3] element_number, [10] is_length_prefix,
  // [11] first_of_item, [12] last_of_item, [14:13] status, [15] zero
  output logic [iso_fs_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                 out_tlast   // message_done
);

  import iso_fs_pkg::*;

  localparam int unsigned LEN_MAX = (1 << LENGTH_BITS) - 1;

  // --------------------------------------------------------------------------
  // pipeline control: input register feeds the parser, result register holds
  // the tagged word; the parser state moves whenever a byte passes through
  // --------------------------------------------------------------------------
  logic       s0_valid_r;
  logic [7:0] s0_byte_r;
  logic       s0_eom_r;
  logic       s0_adv;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  assign s0_adv    = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || s0_adv;

  // --------------------------------------------------------------------------
  // parser state
  // --------------------------------------------------------------------------
  seg_t                   seg_r,       seg_nxt;
  logic [6:0]             elem_r,      elem_nxt;     // also counts bitmap bytes
  logic [LENGTH_BITS-1:0] left_r,      left_nxt;     // body bytes still owed
  logic [1:0]             pfx_left_r,  pfx_left_nxt;
  logic [6:0]             pfx_hi_r,    pfx_hi_nxt;   // first bcd byte of two
  logic [63:0]            pres_r,      pres_nxt;     // element n at bit 64-n
  status_t                err_r,       err_nxt;
  logic                   start_r,     start_nxt;

  // result fields of the current byte
  logic       o_pfx, o_first, o_last;
  logic [6:0] o_elem;
  status_t    o_status;

  // working values
  logic [3:0]             nib_hi, nib_lo;
  logic                   bad_bcd;
  logic [PFX_VAL_W-1:0]   pfx_val;
  logic [7:0]             pfx_kind;
  logic [BODY_W-1:0]      body_raw;
  logic [LENGTH_BITS-1:0] body_sat;
  logic [LENGTH_BITS-1:0] work_left;
  logic                   do_adv;
  logic [63:0]            pres_upd;     // presence bits including this byte

  // next present element search
  logic [6:0] srch_from;
  logic [6:0] srch_n;
  logic       srch_hit;
  logic [7:0] srch_kind;

  assign nib_hi  = s0_byte_r[7:4];
  assign nib_lo  = s0_byte_r[3:0];
  assign bad_bcd = (nib_hi > 4'd9) || (nib_lo > 4'd9);
  assign pfx_val = PFX_VAL_W'(pfx_hi_r) * PFX_VAL_W'(100)
                 + PFX_VAL_W'(nib_hi) * PFX_VAL_W'(10)
                 + PFX_VAL_W'(nib_lo);

  assign pfx_kind = (seg_r == SEG_ELEM) ? elem_kind(elem_r) : KIND_V1H;
  assign body_raw = body_len(pfx_kind, pfx_val);

  // lengths clamp at the counter range
  always_comb begin
    if (32'(body_raw) > LEN_MAX) begin
      body_sat = LENGTH_BITS'(LEN_MAX);
    end else begin
      body_sat = LENGTH_BITS'(body_raw);
    end
  end

  // first 8 bitmap bytes shift into the presence bits
  assign pres_upd = ((seg_r == SEG_BITMAP) && (elem_r < 7'd8)) ?
                    {pres_r[55:0], s0_byte_r} : pres_r;

  // priority encoder: lowest flagged element above srch_from
  assign srch_from = (seg_r == SEG_BITMAP) ? 7'd1 : elem_r;

  always_comb begin
    srch_n   = 7'd0;
    srch_hit = 1'b0;
    for (int m = 64; m >= 1; m--) begin
      if (pres_upd[64-m] && (7'(m) > srch_from)) begin
        srch_n   = 7'(m);
        srch_hit = 1'b1;
      end
    end
  end

  assign srch_kind = elem_kind(srch_n);

  // --------------------------------------------------------------------------
  // next state for the byte held in the input register
  // --------------------------------------------------------------------------
  always_comb begin
    seg_nxt      = seg_r;
    elem_nxt     = elem_r;
    left_nxt     = left_r;
    pfx_left_nxt = pfx_left_r;
    pfx_hi_nxt   = pfx_hi_r;
    pres_nxt     = pres_r;
    err_nxt      = err_r;
    start_nxt    = start_r;
    o_elem       = 7'd0;
    o_pfx        = 1'b0;
    o_first      = 1'b0;
    o_last       = 1'b0;
    o_status     = err_r;
    work_left    = left_r;
    do_adv       = 1'b0;

    if (seg_r != SEG_IDLE) begin
      o_first   = start_r;
      start_nxt = 1'b0;
      if (seg_r == SEG_ELEM) begin
        o_elem = elem_r;
      end

      if (pfx_left_r != 2'd0) begin
        // bcd length prefix byte
        o_pfx = 1'b1;
        if (bad_bcd) begin
          err_nxt      = ST_BCD;
          seg_nxt      = SEG_IDLE;
          elem_nxt     = 7'd0;
          pfx_left_nxt = 2'd0;
          left_nxt     = '0;
        end else begin
          pfx_hi_nxt   = pfx_val[6:0];
          pfx_left_nxt = pfx_left_r - 2'd1;
          if (pfx_left_r == 2'd1) begin
            left_nxt = body_sat;
            if (body_sat == '0) begin
              // empty body: prefix closes the item
              o_last = 1'b1;
              do_adv = 1'b1;
            end
          end
        end
      end else begin
        // body byte
        if (seg_r == SEG_BITMAP) begin
          if (elem_r == 7'd0) begin
            work_left = s0_byte_r[7] ? LENGTH_BITS'(16) : LENGTH_BITS'(8);
          end
          pres_nxt = pres_upd;
          elem_nxt = elem_r + 7'd1;
        end
        if (work_left != '0) begin
          work_left = work_left - LENGTH_BITS'(1);
        end
        left_nxt = work_left;
        if (work_left == '0) begin
          o_last = 1'b1;
          do_adv = 1'b1;
        end
      end

      if (do_adv) begin
        start_nxt  = 1'b1;
        pfx_hi_nxt = 7'd0;
        case (seg_r)
          SEG_LEN: begin
            seg_nxt      = SEG_TPDU;
            pfx_left_nxt = 2'd0;
            left_nxt     = LENGTH_BITS'(5);
          end
          SEG_TPDU: begin
            seg_nxt      = SEG_HEAD;
            pfx_left_nxt = 2'd0;
            left_nxt     = LENGTH_BITS'(6);
          end
          SEG_HEAD: begin
            seg_nxt      = SEG_TYPE;
            pfx_left_nxt = 2'd1;
            left_nxt     = '0;
          end
          SEG_TYPE: begin
            seg_nxt      = SEG_BITMAP;
            pfx_left_nxt = 2'd0;
            left_nxt     = '0;
            elem_nxt     = 7'd0;
          end
          SEG_BITMAP, SEG_ELEM: begin
            if (!srch_hit) begin
              // no more elements: rest of the message is trailing
              seg_nxt      = SEG_IDLE;
              elem_nxt     = 7'd0;
              pfx_left_nxt = 2'd0;
              left_nxt     = '0;
            end else if (srch_kind == KIND_UND) begin
              err_nxt      = ST_UNDEF;
              seg_nxt      = SEG_IDLE;
              elem_nxt     = 7'd0;
              pfx_left_nxt = 2'd0;
              left_nxt     = '0;
            end else begin
              seg_nxt  = SEG_ELEM;
              elem_nxt = srch_n;
              if (srch_kind[7]) begin
                pfx_left_nxt = (srch_kind == KIND_V1H) ? 2'd1 : 2'd2;
                left_nxt     = '0;
              end else begin
                pfx_left_nxt = 2'd0;
                left_nxt     = LENGTH_BITS'(srch_kind[6:0]);
              end
            end
          end
          default: begin
            seg_nxt = SEG_IDLE;
          end
        endcase
      end
    end

    // message ended while something is still owed
    if (s0_eom_r && (seg_nxt != SEG_IDLE) && (err_nxt == ST_OK)) begin
      err_nxt = ST_SHORT;
    end
    o_status = err_nxt;

    // end of message: back to the start of a new message
    if (s0_eom_r) begin
      seg_nxt      = SEG_LEN;
      elem_nxt     = 7'd0;
      left_nxt     = LENGTH_BITS'(2);
      pfx_left_nxt = 2'd0;
      pfx_hi_nxt   = 7'd0;
      pres_nxt     = '0;
      err_nxt      = ST_OK;
      start_nxt    = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seg_r       <= SEG_LEN;
      elem_r      <= 7'd0;
      left_r      <= LENGTH_BITS'(2);
      pfx_left_r  <= 2'd0;
      pfx_hi_r    <= 7'd0;
      pres_r      <= '0;
      err_r       <= ST_OK;
      start_r     <= 1'b1;
    end else begin
      if (in_tready) begin
        s0_valid_r <= in_tvalid;
      end
      if (s0_adv) begin
        out_valid_r <= 1'b1;
        seg_r       <= seg_nxt;
        elem_r      <= elem_nxt;
        left_r      <= left_nxt;
        pfx_left_r  <= pfx_left_nxt;
        pfx_hi_r    <= pfx_hi_nxt;
        pres_r      <= pres_nxt;
        err_r       <= err_nxt;
        start_r     <= start_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_byte_r <= in_tdata;
      s0_eom_r  <= in_tlast;
    end
    if (s0_adv) begin
      out_data_r <= {1'b0, o_status, o_last, o_first, o_pfx, o_elem, seg_r};
      out_last_r <= s0_eom_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- dv/tb_iso8583_field_splitter_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iso8583_field_splitter_unit : self-checking bench for the byte tagger
// feeds whole messages (clean, cut short, bad bcd, undefined element, noise),
// predicts the tag of every accepted word and checks the tagged stream in order
// ----------------------------------------------------------------------------
module tb_iso8583_field_splitter_unit;
  import iso_fs_pkg::*;

  localparam int unsigned LEN_BITS    = LENGTH_BITS_DEF;
  localparam int unsigned LEN_MAX     = (1 << LEN_BITS) - 1;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 20;

  // kinds of message the generator builds
  typedef enum int {
    MSG_CLEAN,
    MSG_CUT,
    MSG_BAD_BCD,
    MSG_UNDEF,
    MSG_NOISE
  } msg_flaw_t;

  // one tagged word, laid out as {out_tlast, out_tdata}
  typedef struct packed {
    logic       done;
    logic       pad;
    logic [1:0] status;
    logic       last;
    logic       first;
    logic       pfx;
    logic [6:0] elem;
    logic [2:0] seg;
  } tag_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // traffic shaping, set by the tests
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic rx_hold   = 1'b0;

  // scoreboard
  tag_t        tags_due[$];
  int          failures    = 0;
  int          cycle_count = 0;
  logic [7:0]  msg_q[$];

  // predictor state: mirrors the parser of the block
  seg_t                cur_seg;
  logic [6:0]          cur_elem;
  logic [LEN_BITS-1:0] left;
  logic [1:0]          pfx_left;
  logic [13:0]         pfx_val;
  logic [63:0]         presence;
  status_t             err;
  logic                at_start;

  iso8583_field_splitter_unit #(
    .LENGTH_BITS (LEN_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // element layout: fixed byte count below 0x80, else a prefixed kind
  // ------------------------------------------------------------------------
  function automatic logic [7:0] element_format(input logic [6:0] n);
    case (n)
      2, 32, 35, 44:                      return KIND_V1H;
      36, 46, 60, 61:                     return KIND_V2H;
      47, 50, 54, 55, 56, 58, 59, 62, 63: return KIND_V2R;
      48:                                 return KIND_V2E;
      25, 26:                             return 8'd1;
      13, 14, 15, 22, 23, 39:             return 8'd2;
      3, 11, 12, 49:                      return 8'd3;
      6:                                  return 8'd4;
      4, 38:                              return 8'd6;
      41, 52, 53, 64:                     return 8'd8;
      37:                                 return 8'd12;
      42:                                 return 8'd15;
      5:                                  return 8'd16;
      default:                            return KIND_UND;
    endcase
  endfunction

  // body size after a length prefix, clipped to the counter width
  function automatic int body_bytes(input logic [7:0] kind, input int v);
    int n;
    if (kind == KIND_V2R) begin
      n = v;
    end else if (kind == KIND_V2E) begin
      n = v + (v & 1);
    end else begin
      n = (v + 1) / 2;
    end
    return (n > LEN_MAX) ? LEN_MAX : n;
  endfunction

  task automatic open_segment(input seg_t s);
    cur_seg  = s;
    at_start = 1'b1;
    pfx_left = '0;
    pfx_val  = '0;
    left     = '0;
    case (s)
      SEG_LEN:    left = LEN_BITS'(2);
      SEG_TPDU:   left = LEN_BITS'(5);
      SEG_HEAD:   left = LEN_BITS'(6);
      SEG_TYPE:   pfx_left = 2'd1;
      SEG_BITMAP: cur_elem = '0;
      default: ;
    endcase
  endtask

  task automatic reset_parser();
    presence = '0;
    err      = ST_OK;
    cur_elem = '0;
    open_segment(SEG_LEN);
  endtask

  // nothing more to parse: remaining words are trailing
  task automatic park_parser();
    cur_seg  = SEG_IDLE;
    cur_elem = '0;
    pfx_left = '0;
    left     = '0;
  endtask

  // move to the next element flagged in the primary bitmap
  task automatic seek_element(input int from);
    int         n;
    logic [7:0] fmt;
    n = from + 1;
    while (n <= 64 && !presence[64 - n]) n++;
    if (n > 64) begin
      park_parser();
      return;
    end
    fmt = element_format(7'(n));
    if (fmt == KIND_UND) begin
      err = ST_UNDEF;
      park_parser();
      return;
    end
    cur_seg  = SEG_ELEM;
    cur_elem = 7'(n);
    at_start = 1'b1;
    pfx_val  = '0;
    if (fmt[7]) begin
      pfx_left = (fmt == KIND_V1H) ? 2'd1 : 2'd2;
      left     = '0;
    end else begin
      pfx_left = '0;
      left     = LEN_BITS'(fmt);
    end
  endtask

  task automatic step_on();
    if (cur_seg < SEG_BITMAP) begin
      open_segment(seg_t'(cur_seg + 1));
    end else if (cur_seg == SEG_BITMAP) begin
      seek_element(1);
    end else begin
      seek_element(int'(cur_elem));
    end
  endtask

  // expected tag of one accepted word, advancing the parser state
  task automatic tag_byte(input logic [7:0] b, input logic eom, output tag_t t);
    seg_t       seg;
    logic [6:0] elem;
    logic       pfx, first, last;
    int         hi, lo;
    logic [7:0] kind;
    seg   = cur_seg;
    elem  = '0;
    pfx   = 1'b0;
    first = 1'b0;
    last  = 1'b0;
    if (seg != SEG_IDLE) begin
      first    = at_start;
      at_start = 1'b0;
      if (seg == SEG_ELEM) elem = cur_elem;
      if (pfx_left != 0) begin
        hi  = int'(b[7:4]);
        lo  = int'(b[3:0]);
        pfx = 1'b1;
        if (hi > 9 || lo > 9) begin
          err = ST_BCD;
          park_parser();
        end else begin
          pfx_val  = 14'(pfx_val * 100 + hi * 10 + lo);
          pfx_left = pfx_left - 2'd1;
          if (pfx_left == 0) begin
            kind = (seg == SEG_ELEM) ? element_format(cur_elem) : KIND_V1H;
            left = LEN_BITS'(body_bytes(kind, int'(pfx_val)));
            // empty body closes the item on its prefix
            if (left == 0) begin
              last = 1'b1;
              step_on();
            end
          end
        end
      end else begin
        if (seg == SEG_BITMAP) begin
          // bitmap size comes from the secondary-bitmap flag of the first byte
          if (cur_elem == 0) left = b[7] ? LEN_BITS'(16) : LEN_BITS'(8);
          if (cur_elem < 8) presence = {presence[55:0], b};
          cur_elem = cur_elem + 7'd1;
        end
        if (left > 0) left = left - LEN_BITS'(1);
        if (left == 0) begin
          last = 1'b1;
          step_on();
        end
      end
    end
    // message ended with something still owed
    if (eom && cur_seg != SEG_IDLE && err == ST_OK) err = ST_SHORT;
    t.done   = eom;
    t.pad    = 1'b0;
    t.status = err;
    t.last   = last;
    t.first  = first;
    t.pfx    = pfx;
    t.elem   = elem;
    t.seg    = seg;
    if (eom) reset_parser();
  endtask

  // ------------------------------------------------------------------------
  // message generation
  // ------------------------------------------------------------------------
  function automatic logic [7:0] to_bcd(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // push one nibble of a prefix out of the decimal range
  function automatic logic [7:0] spoil_bcd(input logic [7:0] p);
    if ($urandom_range(0, 1) == 0) return {4'($urandom_range(10, 15)), p[3:0]};
    return {p[7:4], 4'($urandom_range(10, 15))};
  endfunction

  function automatic int pick_element(input logic defined);
    int n;
    do n = $urandom_range(2, 64);
    while ((element_format(7'(n)) == KIND_UND) == defined);
    return n;
  endfunction

  task automatic push_random(input int count);
    repeat (count) msg_q.push_back(8'($urandom));
  endtask

  task automatic build_message(input msg_flaw_t flaw);
    int          v, cut;
    logic [63:0] map;
    logic [7:0]  fmt, p, p_hi, p_lo;
    logic        spoil_type, spoil_elem;
    msg_q.delete();
    if (flaw == MSG_NOISE) begin
      push_random($urandom_range(1, 40));
      return;
    end
    spoil_type = (flaw == MSG_BAD_BCD) && ($urandom_range(0, 2) == 0);
    spoil_elem = (flaw == MSG_BAD_BCD) && !spoil_type;
    // length, tpdu and header
    push_random(13);
    // message type with its one-byte prefix
    v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 5);
    p = to_bcd(v);
    if (spoil_type) begin
      msg_q.push_back(spoil_bcd(p));
      push_random($urandom_range(0, 3));
      return;
    end
    msg_q.push_back(p);
    push_random((v + 1) / 2);
    // bitmap, sometimes with the secondary half
    map     = '0;
    map[63] = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 7)) map[64 - pick_element(1'b1)] = 1'b1;
    if (flaw == MSG_UNDEF) map[64 - pick_element(1'b0)] = 1'b1;
    for (int i = 0; i < 8; i++) msg_q.push_back(map[63 - 8 * i -: 8]);
    if (map[63]) push_random(8);
    // data elements in ascending order
    for (int n = 2; n <= 64; n++) begin
      if (!map[64 - n]) continue;
      fmt = element_format(7'(n));
      if (fmt == KIND_UND) break;
      if (!fmt[7]) begin
        push_random(fmt);
      end else if (fmt == KIND_V1H) begin
        v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 12);
        p = to_bcd(v);
        if (spoil_elem) begin
          msg_q.push_back(spoil_bcd(p));
          push_random($urandom_range(0, 3));
          return;
        end
        msg_q.push_back(p);
        push_random(body_bytes(fmt, v));
      end else begin
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 12);
        // long bodies only in messages that stop inside them
        if (flaw == MSG_CUT && $urandom_range(0, 2) == 0) v = $urandom_range(100, 9999);
        p_hi = to_bcd(v / 100);
        p_lo = to_bcd(v % 100);
        if (spoil_elem) begin
          if ($urandom_range(0, 1) == 0) begin
            msg_q.push_back(spoil_bcd(p_hi));
          end else begin
            msg_q.push_back(p_hi);
            msg_q.push_back(spoil_bcd(p_lo));
          end
          push_random($urandom_range(0, 3));
          return;
        end
        msg_q.push_back(p_hi);
        msg_q.push_back(p_lo);
        if (v >= 100) begin
          push_random($urandom_range(0, 6));
          return;
        end
        push_random(body_bytes(fmt, v));
      end
    end
    if (flaw == MSG_CUT) begin
      cut = $urandom_range(1, msg_q.size() - 1);
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end else begin
      // trailing words after the last element
      push_random(($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
    end
  endtask

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  // offer one word, wait for the handshake, then record its expected tag
  task automatic send_word(input logic [7:0] b, input logic eom);
    tag_t t;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tag_byte(b, eom, t);
    tags_due.push_back(t);
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_word(msg_q[i], i == msg_q.size() - 1);
  endtask

  // lone end flag, then a message cut off in the tpdu
  task automatic test_early_end();
    idle_pct  = 0;
    stall_pct = 0;
    msg_q = '{8'h7F};
    send_message();
    msg_q = '{8'hFF, 8'h00, 8'h80};
    send_message();
  endtask

  // header of extreme bytes, then a type prefix with a nibble above nine
  task automatic test_bad_type_prefix();
    msg_q.delete();
    for (int i = 0; i < 13; i++) msg_q.push_back(i[0] ? 8'hFF : 8'h00);
    msg_q.push_back(8'h9F);
    msg_q.push_back(8'h12);
    msg_q.push_back(8'h34);
    send_message();
  endtask

  task automatic test_random_stream(input int idle, input int stall, input int budget);
    int        sent;
    msg_flaw_t flaw;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        5, 9:    flaw = MSG_CUT;
        6:       flaw = MSG_BAD_BCD;
        7:       flaw = MSG_UNDEF;
        8:       flaw = MSG_NOISE;
        default: flaw = MSG_CLEAN;
      endcase
      build_message(flaw);
      send_message();
      sent += msg_q.size();
    end
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        repeat (2) begin
          build_message(MSG_CLEAN);
          send_message();
        end
      end
    join
  endtask

  initial begin
    reset_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_early_end();
    test_bad_type_prefix();
    test_random_stream(0, 0, 200);
    test_random_stream(75, 0, 200);
    test_random_stream(0, 75, 200);
    test_random_stream(24, 24, 200);
    test_backpressure();

    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (tags_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // receiver and checker
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic string tag_text(input tag_t t);
    return $sformatf("seg=%0d elem=%0d pfx=%0b first=%0b last=%0b %s",
                     t.seg, t.elem, t.pfx, t.first, t.last,
                     $sformatf("status=%0d done=%0b pad=%0b", t.status, t.done, t.pad));
  endfunction

  function automatic void flag_failure(input string text);
    failures++;
    if (failures <= 10) $display("%s", text);
  endfunction

  tag_t seen_tag, want_tag;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_tag = {out_tlast, out_tdata};
      if (tags_due.size() == 0) begin
        flag_failure($sformatf("unexpected word: %s", tag_text(seen_tag)));
      end else begin
        want_tag = tags_due.pop_front();
        if (seen_tag.seg !== want_tag.seg || seen_tag.elem !== want_tag.elem ||
            seen_tag.pfx !== want_tag.pfx || seen_tag.first !== want_tag.first ||
            seen_tag.last !== want_tag.last || seen_tag.status !== want_tag.status ||
            seen_tag.done !== want_tag.done || seen_tag.pad !== want_tag.pad) begin
          flag_failure($sformatf("mismatch: expected %s / got %s",
                                 tag_text(want_tag), tag_text(seen_tag)));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
